FILE: hw/rtl/u8u16_pkg.sv
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

  localparam int unsigned AccW = 31;  // code point accumulator width
  localparam int unsigned RemW = 3;   // continuation bytes still due

  // Lead byte thresholds
  localparam logic [7:0] AsciiLimit = 8'h80;
  localparam logic [7:0] Lead2Limit = 8'hE0;
  localparam logic [7:0] Lead3Limit = 8'hF0;
  localparam logic [7:0] Lead4Limit = 8'hF8;
  localparam logic [7:0] Lead5Limit = 8'hFC;

  localparam logic [5:0]  ContMask  = 6'h3F;
  localparam logic [19:0] PlaneBase = 20'h10000;
  localparam logic [15:0] HiSurBase = 16'hD800;
  localparam logic [5:0]  LoSurTop  = 6'b110111;  // 0xDC00 >> 10

  // Result of one decode step as seen by the output side
  typedef struct packed {
    logic        emit;      // at least one unit produced
    logic        pair;      // a second (low surrogate) unit follows
    logic [15:0] unit0;     // first unit
    logic        last0;     // first unit closes this byte's run
    logic        done0;     // first unit closes the text
    logic        dropped0;  // first unit reports a dropped sequence
    logic [15:0] unit1;     // low surrogate
    logic        done1;     // low surrogate closes the text
  } step_res_t;

  // Bits kept from a lead byte, by its continuation count
  function automatic logic [7:0] keep_mask(input logic [RemW-1:0] len);
    logic [7:0] m;
    case (len)
      3'd1:    m = 8'h1F;
      3'd2:    m = 8'h0F;
      3'd3:    m = 8'h07;
      3'd4:    m = 8'h03;
      3'd5:    m = 8'h01;
      default: m = 8'h7F;
    endcase
    return m;
  endfunction

endpackage

FILE: hw/rtl/u8u16_decode.sv
// ----------------------------------------------------------------------------
// u8u16_decode
// One decode step: next accumulator state and the UTF-16 units for a byte.
// ----------------------------------------------------------------------------
module u8u16_decode (
  input  logic [u8u16_pkg::AccW-1:0] acc_i,
  input  logic [u8u16_pkg::RemW-1:0] rem_i,
  input  logic [7:0]                 data_byte_i,
  input  logic                       end_of_text_i,
  output logic [u8u16_pkg::AccW-1:0] acc_o,
  output logic [u8u16_pkg::RemW-1:0] rem_o,
  output u8u16_pkg::step_res_t       res_o
);
  import u8u16_pkg::*;

  logic [RemW-1:0] lead_len;
  logic [AccW-1:0] acc_nx;
  logic [RemW-1:0] rem_nx;
  logic            cp_done;
  logic [AccW-1:0] cp;
  logic            cp_pair;
  logic [19:0]     cp_off;

  // Continuation count from the lead byte thresholds
  always_comb begin
    if (data_byte_i < Lead2Limit)      lead_len = 3'd1;
    else if (data_byte_i < Lead3Limit) lead_len = 3'd2;
    else if (data_byte_i < Lead4Limit) lead_len = 3'd3;
    else if (data_byte_i < Lead5Limit) lead_len = 3'd4;
    else                               lead_len = 3'd5;
  end

  // Accumulator update
  always_comb begin
    acc_nx  = acc_i;
    rem_nx  = rem_i;
    cp_done = 1'b0;
    cp      = '0;
    if (rem_i == '0) begin
      if (data_byte_i < AsciiLimit) begin
        cp_done = 1'b1;
        cp      = AccW'(data_byte_i);
      end else begin
        acc_nx = AccW'(data_byte_i & keep_mask(lead_len));
        rem_nx = lead_len;
      end
    end else begin
      acc_nx = {acc_i[AccW-7:0], data_byte_i[5:0] & ContMask};
      rem_nx = rem_i - 3'd1;
      if (rem_nx == '0) begin
        cp_done = 1'b1;
        cp      = acc_nx;
        acc_nx  = '0;
      end
    end
    // end of text always returns to the idle state
    if (end_of_text_i) begin
      acc_nx = '0;
      rem_nx = '0;
    end
  end

  // Code point to UTF-16 units
  assign cp_pair = |cp[AccW-1:16];
  assign cp_off  = cp[19:0] - PlaneBase;

  always_comb begin
    res_o          = '0;
    res_o.unit1    = {LoSurTop, cp_off[9:0]};
    res_o.done1    = end_of_text_i;
    if (end_of_text_i && !cp_done && rem_i != '0) begin
      // text ended inside a sequence
      res_o.emit     = 1'b1;
      res_o.last0    = 1'b1;
      res_o.done0    = 1'b1;
      res_o.dropped0 = 1'b1;
    end else if (end_of_text_i && !cp_done) begin
      // text ended on a lead byte
      res_o.emit     = 1'b1;
      res_o.last0    = 1'b1;
      res_o.done0    = 1'b1;
      res_o.dropped0 = 1'b1;
    end else if (cp_done) begin
      res_o.emit  = 1'b1;
      res_o.pair  = cp_pair;
      res_o.unit0 = cp_pair ? (HiSurBase + 16'(cp_off[19:10])) : cp[15:0];
      res_o.last0 = !cp_pair;
      res_o.done0 = end_of_text_i && !cp_pair;
    end
  end

  assign acc_o = acc_nx;
  assign rem_o = rem_nx;

endmodule

FILE: hw/rtl/utf8_to_utf16_transcoder.sv
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder
// UTF-8 byte stream in, UTF-16 code units out, valid/ready on both sides.
// ----------------------------------------------------------------------------
// One byte is taken per cycle while in_ready_o is high. A byte that finishes
// a code point has its result registered before its units appear. A code
// point up to 0xFFFF gives one unit. A code point above 0xFFFF gives a high
// and then a low surrogate, in turn, from the same output register. While
// the output register is busy, a spare register holds the result of the
// next byte, so a byte is not stalled after a pair. in_ready_o is low only
// while that spare register is full, which happens only when the output
// side stalls or the output rate is the limit. Lead bytes and unfinished
// continuation bytes give no unit. When end_of_text marks a byte inside an
// open sequence (or a lead byte), the sequence is dropped and a single unit
// 0 with partial_dropped set closes the text. No validation is done: stray
// and malformed bytes are decoded as they fall.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_text_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] code_unit_o,
  output logic        last_of_run_o,
  output logic        text_done_o,
  output logic        partial_dropped_o
);
  import u8u16_pkg::*;

  logic [AccW-1:0] acc_q, acc_d;
  logic [RemW-1:0] rem_q, rem_d;
  step_res_t       res;

  logic      out_valid_q;
  step_res_t out_res_q;
  logic      out_second_q;  // showing the low surrogate
  logic      skid_valid_q;
  step_res_t skid_res_q;

  logic in_fire, new_res, out_pop, out_more, out_free;

  u8u16_decode u_dec (
    .acc_i         (acc_q),
    .rem_i         (rem_q),
    .data_byte_i   (data_byte_i),
    .end_of_text_i (end_of_text_i),
    .acc_o         (acc_d),
    .rem_o         (rem_d),
    .res_o         (res)
  );

  // Handshakes; output slot frees when empty or its last unit is taken
  assign in_ready_o = !skid_valid_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign new_res    = in_fire && res.emit;
  assign out_pop    = out_valid_q && out_ready_i;
  assign out_more   = out_res_q.pair && !out_second_q;
  assign out_free   = !out_valid_q || (out_pop && !out_more);

  // Decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      rem_q <= '0;
    end else if (in_fire) begin
      acc_q <= acc_d;
      rem_q <= rem_d;
    end
  end

  // Output register: spare result first, else the new one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      out_res_q    <= '0;
      out_second_q <= 1'b0;
    end else if (out_free) begin
      out_second_q <= 1'b0;
      if (skid_valid_q) begin
        out_valid_q <= 1'b1;
        out_res_q   <= skid_res_q;
      end else begin
        out_valid_q <= new_res;
        if (new_res) out_res_q <= res;
      end
    end else if (out_pop) begin
      out_second_q <= 1'b1;
    end
  end

  // Spare register for a result that arrives while the output is busy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_valid_q <= 1'b0;
      skid_res_q   <= '0;
    end else if (skid_valid_q) begin
      if (out_free) skid_valid_q <= 1'b0;
    end else if (new_res && !out_free) begin
      skid_valid_q <= 1'b1;
      skid_res_q   <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign code_unit_o       = out_second_q ? out_res_q.unit1 : out_res_q.unit0;
  assign last_of_run_o     = out_second_q || out_res_q.last0;
  assign text_done_o       = out_second_q ? out_res_q.done1 : out_res_q.done0;
  assign partial_dropped_o = !out_second_q && out_res_q.dropped0;

endmodule
